// ----- rtl/core/pfx_pkg.sv -----
// Package for the postfix expression evaluator: payload types, codes and sizes.
package pfx_pkg;

  // Operand store sizing
  localparam int STACK_DEPTH = 64;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
  localparam int DATA_W      = 32;

  // Status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_UNDERFLOW = 3'd1;
  localparam logic [2:0] ST_DIVZERO   = 3'd2;
  localparam logic [2:0] ST_INVALID   = 3'd3;
  localparam logic [2:0] ST_OVERFLOW  = 3'd4;

  // Characters
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  // Channel payloads
  typedef struct packed {
    logic [7:0] symbol;
    logic       is_final;
  } in_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [2:0]         status;
  } out_t;

  // Operand store ports
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } pfx_wr_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } pfx_rd_t;

  // Divider request and response
  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } pfx_div_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quotient;
  } pfx_div_rsp_t;

endpackage

// ----- rtl/core/pfx_stack_ram.sv -----
// Operand store: one write port, one read port with registered read data.
module pfx_stack_ram
  import pfx_pkg::*;
(
  input  logic              clk,
  input  pfx_wr_t           wr,
  input  pfx_rd_t           rd,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [STACK_DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Read port with registered read data
  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data <= mem[rd.addr];
    end
  end

endmodule

// ----- rtl/core/pfx_divider.sv -----
// Signed 32-bit divider, truncating toward zero, one quotient bit per cycle.
module pfx_divider
  import pfx_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  pfx_div_req_t req,
  output pfx_div_rsp_t rsp
);

  localparam int CNT_W = $clog2(DATA_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              neg_r, neg_nxt;
  logic [DATA_W-1:0] rem_r, rem_nxt;
  logic [DATA_W-1:0] quo_r, quo_nxt;
  logic [DATA_W-1:0] dvs_r, dvs_nxt;

  logic [DATA_W:0]   trial;
  logic [DATA_W:0]   diff;

  // Restoring step on magnitudes
  assign trial = {rem_r, quo_r[DATA_W-1]};
  assign diff  = trial - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      neg_nxt  = req.dividend[DATA_W-1] ^ req.divisor[DATA_W-1];
      rem_nxt  = '0;
      quo_nxt  = req.dividend[DATA_W-1] ? (DATA_W'(0) - req.dividend) : req.dividend;
      dvs_nxt  = req.divisor[DATA_W-1] ? (DATA_W'(0) - req.divisor) : req.divisor;
    end else if (busy_r) begin
      if (!diff[DATA_W]) begin
        rem_nxt = diff[DATA_W-1:0];
      end else begin
        rem_nxt = trial[DATA_W-1:0];
      end
      quo_nxt = {quo_r[DATA_W-2:0], ~diff[DATA_W]};
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(DATA_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    neg_r <= neg_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  // Sign fix on the way out
  assign rsp.done     = done_r;
  assign rsp.quotient = neg_r ? (DATA_W'(0) - quo_r) : quo_r;

endmodule

// ----- rtl/core/postfix_expression_evaluator_top.sv -----
// Postfix expression evaluator: sequencer, top-of-stack register and result port.
//
// One transaction on the input channel (in_valid/in_ready, in_data) carries one
// expression character and a final flag. A digit pushes its value; '+', '-',
// '*' and '/' pop two 32-bit signed operands and push the result. On the final
// character one result transaction (out_valid/out_ready, out_data) carries the
// top of stack and a status code; value is zero whenever status is not ok.
// The first error sticks until the final character; the following characters
// are ignored.
// Steps per character: a digit is handled on acceptance; '+', '-', '*' wait for the
// operand store read; '/' does the store read, then the bit-serial divider at one quotient bit per cycle.
// A final character then passes through the output state to load the output register.
// Error cases and ignored characters are handled on acceptance.
// Reset (rst_n low, synchronous) empties the stack and clears the error; the
// operand store itself is not cleared and needs no clearing pass.
// A waiting result does not stall non-final characters; a final character
// holds in the output stage until the previous result has been taken.
module postfix_expression_evaluator_top
  import pfx_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_DIV  = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t             state_r, state_nxt;
  logic [DEPTH_W-1:0] depth_r, depth_nxt;
  logic [2:0]         err_r, err_nxt;
  logic [DATA_W-1:0]  tos_r, tos_nxt;
  logic [7:0]         op_r, op_nxt;
  logic               fin_r, fin_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_t               out_r, out_nxt;

  pfx_wr_t            wr;
  pfx_rd_t            rd;
  logic [DATA_W-1:0]  rd_data;
  pfx_div_req_t       div_req;
  pfx_div_rsp_t       div_rsp;

  logic               in_fire;
  logic               is_digit;
  logic               is_op;
  logic [DATA_W-1:0]  alu_res;
  logic [DATA_W-1:0]  prod;
  logic               slot_free;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign is_digit  = (in_data.symbol >= CH_0) && (in_data.symbol <= CH_9);
  assign is_op     = (in_data.symbol == CH_PLUS) || (in_data.symbol == CH_MINUS) ||
                     (in_data.symbol == CH_STAR) || (in_data.symbol == CH_SLASH);
  assign slot_free = !out_valid_r || out_ready;
  assign prod      = rd_data * tos_r;

  // Add, subtract, multiply on the left operand from the store
  always_comb begin
    unique case (op_r)
      CH_PLUS:  alu_res = rd_data + tos_r;
      CH_MINUS: alu_res = rd_data - tos_r;
      CH_STAR:  alu_res = prod;
      default:  alu_res = rd_data + tos_r;
    endcase
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    depth_nxt     = depth_r;
    err_nxt       = err_r;
    tos_nxt       = tos_r;
    op_nxt        = op_r;
    fin_nxt       = fin_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    wr            = '0;
    rd            = '0;
    div_req       = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          fin_nxt   = in_data.is_final;
          op_nxt    = in_data.symbol;
          state_nxt = in_data.is_final ? S_FIN : S_IDLE;
          if (err_r == ST_OK) begin
            if (is_digit) begin
              if (depth_r == DEPTH_W'(STACK_DEPTH)) begin
                err_nxt = ST_OVERFLOW;
              end else begin
                // Spill the old top into the store
                wr.en     = (depth_r != '0);
                wr.addr   = ADDR_W'(depth_r - DEPTH_W'(1));
                wr.data   = tos_r;
                tos_nxt   = DATA_W'(in_data.symbol - CH_0);
                depth_nxt = depth_r + DEPTH_W'(1);
              end
            end else if (depth_r < DEPTH_W'(2)) begin
              err_nxt = ST_UNDERFLOW;
            end else if (!is_op) begin
              err_nxt = ST_INVALID;
            end else if ((in_data.symbol == CH_SLASH) && (tos_r == '0)) begin
              err_nxt = ST_DIVZERO;
            end else begin
              // Fetch the left operand from below the top
              rd.en     = 1'b1;
              rd.addr   = ADDR_W'(depth_r - DEPTH_W'(2));
              state_nxt = S_READ;
            end
          end
        end
      end
      S_READ: begin
        if (op_r == CH_SLASH) begin
          div_req.start    = 1'b1;
          div_req.dividend = rd_data;
          div_req.divisor  = tos_r;
          state_nxt        = S_DIV;
        end else begin
          tos_nxt   = alu_res;
          depth_nxt = depth_r - DEPTH_W'(1);
          state_nxt = fin_r ? S_FIN : S_IDLE;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          tos_nxt   = div_rsp.quotient;
          depth_nxt = depth_r - DEPTH_W'(1);
          state_nxt = fin_r ? S_FIN : S_IDLE;
        end
      end
      S_FIN: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          if (err_r != ST_OK) begin
            out_nxt.value  = '0;
            out_nxt.status = err_r;
          end else if (depth_r == '0) begin
            out_nxt.value  = '0;
            out_nxt.status = ST_UNDERFLOW;
          end else begin
            out_nxt.value  = $signed(tos_r);
            out_nxt.status = ST_OK;
          end
          depth_nxt = '0;
          err_nxt   = ST_OK;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      depth_r     <= '0;
      err_r       <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      depth_r     <= depth_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    tos_r <= tos_nxt;
    op_r  <= op_nxt;
    fin_r <= fin_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  pfx_stack_ram u_ram (
    .clk     (clk),
    .wr      (wr),
    .rd      (rd),
    .rd_data (rd_data)
  );

  pfx_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

endmodule

// ----- test/postfix_expression_evaluator_top_test.sv -----
// Testbench for the postfix expression evaluator: directed and random character streams against a predictor.
`timescale 1ns / 1ps

module postfix_expression_evaluator_top_test
  import pfx_pkg::*;
();

  // Characters outside the operator set
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  localparam int RANDOM_ITEMS = 1700;
  localparam int DRAIN_CYCLES = 40;

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_HALF,
    READY_SPARSE,
    READY_TOGGLE
  } ready_mode_e;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  // Predicted evaluator state
  logic [31:0] operand_stack [STACK_DEPTH];
  int          operand_count = 0;
  logic [2:0]  pending_error = ST_OK;

  in_t  pending_symbols[$];
  out_t expected_results[$];
  out_t oldest_result;

  int total_items = 0;
  int accepted_count = 0;
  int fail_count = 0;
  int burst_left = 0;
  int gap_left = 0;
  int mode_left = 0;
  ready_mode_e ready_mode = READY_ALWAYS;

  postfix_expression_evaluator_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("MISMATCH: %s", msg);
    end
  endfunction

  // Advance the predicted stack by one character; a final character yields a result
  task automatic evaluate_symbol(in_t item);
    logic [31:0] lhs;
    logic [31:0] rhs;
    logic [31:0] res;
    logic [31:0] lhs_mag;
    logic [31:0] rhs_mag;
    logic [31:0] quot;
    out_t result;
    if (pending_error == ST_OK) begin
      if (item.symbol >= CH_0 && item.symbol <= CH_9) begin
        if (operand_count >= STACK_DEPTH) begin
          pending_error = ST_OVERFLOW;
        end else begin
          operand_stack[operand_count] = 32'(item.symbol - CH_0);
          operand_count++;
        end
      end else if (operand_count < 2) begin
        // underflow wins over an unknown character
        pending_error = ST_UNDERFLOW;
      end else begin
        rhs = operand_stack[operand_count - 1];
        lhs = operand_stack[operand_count - 2];
        res = '0;
        case (item.symbol)
          CH_PLUS:  res = lhs + rhs;
          CH_MINUS: res = lhs - rhs;
          CH_STAR:  res = lhs * rhs;
          CH_SLASH: begin
            if (rhs == 32'd0) begin
              pending_error = ST_DIVZERO;
            end else begin
              // divide magnitudes, truncate toward zero; MIN / -1 wraps to MIN
              lhs_mag = lhs[31] ? 32'd0 - lhs : lhs;
              rhs_mag = rhs[31] ? 32'd0 - rhs : rhs;
              quot    = lhs_mag / rhs_mag;
              res     = (lhs[31] ^ rhs[31]) ? 32'd0 - quot : quot;
            end
          end
          default: pending_error = ST_INVALID;
        endcase
        if (pending_error == ST_OK) begin
          operand_count--;
          operand_stack[operand_count - 1] = res;
        end
      end
    end
    if (item.is_final) begin
      if (pending_error == ST_OK && operand_count == 0) begin
        pending_error = ST_UNDERFLOW;
      end
      result.status = pending_error;
      if (pending_error == ST_OK) begin
        result.value = operand_stack[operand_count - 1];
      end else begin
        result.value = '0;
      end
      expected_results.push_back(result);
      operand_count = 0;
      pending_error = ST_OK;
    end
  endtask

  task automatic add_char(logic [7:0] sym, logic fin);
    in_t item;
    item.symbol   = sym;
    item.is_final = fin;
    pending_symbols.push_back(item);
  endtask

  function automatic logic [7:0] pick_operator();
    case ($urandom_range(0, 3))
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_STAR;
      default: return CH_SLASH;
    endcase
  endfunction

  // Well-formed expression with the given number of digits, optionally damaged
  task automatic add_expression(int unsigned pushes, bit push_first, bit corrupt);
    logic [7:0]  text[$];
    int unsigned left;
    int          depth;
    int          pos;
    left  = pushes;
    depth = 0;
    while (left != 0 || depth > 1) begin
      if (left != 0 && (depth < 2 || push_first || $urandom_range(0, 2) != 0)) begin
        text.push_back(CH_0 + 8'($urandom_range(0, 9)));
        left--;
        depth++;
      end else begin
        text.push_back(pick_operator());
        depth--;
      end
    end
    if (corrupt) begin
      pos = $urandom_range(0, text.size() - 1);
      case ($urandom_range(0, 2))
        0: text[pos] = 8'($urandom_range(0, 255));
        1: text.insert(pos, pick_operator());
        default: begin
          if (text.size() > 1) text.delete(pos);
          else text[pos] = pick_operator();
        end
      endcase
    end
    foreach (text[k]) begin
      add_char(text[k], k == text.size() - 1);
    end
  endtask

  // 2 * 8^10 wraps to the most negative value, then divide by (0 - 1)
  task automatic add_wrap_division();
    add_char(CH_0 + 8'd2, 1'b0);
    repeat (10) begin
      add_char(CH_0 + 8'd8, 1'b0);
      add_char(CH_STAR, 1'b0);
    end
    add_char(CH_0, 1'b0);
    add_char(CH_0 + 8'd1, 1'b0);
    add_char(CH_MINUS, 1'b0);
    add_char(CH_SLASH, 1'b1);
  endtask

  // Sender: bursts of transactions separated by random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (in_valid && in_ready) begin
        evaluate_symbol(in_data);
        accepted_count++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_symbols.size() != 0) begin
          in_valid <= 1'b1;
          in_data  <= pending_symbols.pop_front();
          if (burst_left <= 1) begin
            burst_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                       : $urandom_range(1, 24);
            gap_left   <= ($urandom_range(0, 3) == 0) ? $urandom_range(9, 40)
                                                       : $urandom_range(0, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall pattern switches between modes; results checked in order
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      ready_mode <= READY_ALWAYS;
      mode_left  <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          note_failure($sformatf("unexpected result: value %0d status %0d",
                                 out_data.value, out_data.status));
        end else begin
          oldest_result = expected_results.pop_front();
          if (out_data.value !== oldest_result.value) begin
            note_failure($sformatf("value: expected %0d, got %0d",
                                   oldest_result.value, out_data.value));
          end
          if (out_data.status !== oldest_result.status) begin
            note_failure($sformatf("status: expected %0d, got %0d",
                                   oldest_result.status, out_data.status));
          end
        end
      end
      if (mode_left == 0) begin
        ready_mode <= ready_mode_e'($urandom_range(0, 3));
        mode_left  <= $urandom_range(20, 120);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (ready_mode)
        READY_ALWAYS: out_ready <= 1'b1;
        READY_HALF:   out_ready <= 1'($urandom_range(0, 1));
        READY_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
        default:      out_ready <= ~out_ready;
      endcase
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int pick;
    int n;
    // single digits at both ends
    add_char(CH_0, 1'b1);
    add_char(CH_9, 1'b1);
    // operators short of operands
    add_char(CH_PLUS, 1'b1);
    add_char(CH_0 + 8'd7, 1'b0);
    add_char(CH_MINUS, 1'b1);
    // 9 9 * 5 +
    add_char(CH_9, 1'b0);
    add_char(CH_9, 1'b0);
    add_char(CH_STAR, 1'b0);
    add_char(CH_0 + 8'd5, 1'b0);
    add_char(CH_PLUS, 1'b1);
    // (0 - 7) / 2 truncates toward zero
    add_char(CH_0, 1'b0);
    add_char(CH_0 + 8'd7, 1'b0);
    add_char(CH_MINUS, 1'b0);
    add_char(CH_0 + 8'd2, 1'b0);
    add_char(CH_SLASH, 1'b1);
    // zero divisor
    add_char(CH_0 + 8'd6, 1'b0);
    add_char(CH_0, 1'b0);
    add_char(CH_SLASH, 1'b1);
    // unknown character with two operands
    add_char(CH_0 + 8'd1, 1'b0);
    add_char(CH_0 + 8'd2, 1'b0);
    add_char(CH_SPACE, 1'b1);
    // unknown character on an empty stack reports underflow
    add_char(CH_NEWLINE, 1'b1);
    // sticky error: later characters ignored
    add_char(CH_0 + 8'd1, 1'b0);
    add_char(CH_PLUS, 1'b0);
    add_char(CH_0 + 8'd5, 1'b1);

    // full stack, one digit too many, wrapping division
    add_expression(STACK_DEPTH, 1'b1, 1'b0);
    add_expression(STACK_DEPTH + 1, 1'b1, 1'b0);
    add_wrap_division();

    // random traffic tops the directed part up to the total
    n = RANDOM_ITEMS;
    while (pending_symbols.size() < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        add_expression($urandom_range(1, 12), 1'b0, 1'b0);
      end else if (pick < 75) begin
        add_expression($urandom_range(1, 12), 1'b0, 1'b1);
      end else if (pick < 86) begin
        // raw bytes
        repeat ($urandom_range(0, 5)) add_char(8'($urandom_range(0, 255)), 1'($urandom));
        add_char(8'($urandom_range(0, 255)), 1'b1);
      end else if (pick < 97) begin
        add_expression($urandom_range(1, 3), 1'b0, 1'($urandom_range(0, 1)));
      end else if (pick < 99) begin
        add_expression($urandom_range(STACK_DEPTH - 4, STACK_DEPTH + 2),
                       1'($urandom_range(0, 1)), 1'b0);
      end else begin
        add_wrap_division();
      end
    end
    total_items = pending_symbols.size();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_count != total_items) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #8_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
